@@ sv/gdai_pkg.sv @@
// Shared widths, register indexes, constants and lane control type for the
// gyro angle integrator. No dependencies.
package gdai_pkg;

  localparam int RAW_W  = 16;  // raw rate sample
  localparam int BIAS_W = 20;  // calibration bias sum
  localparam int RATE_W = 21;  // bias-corrected rate
  localparam int ANG_W  = 41;  // angle, 2^-32 degree
  localparam int GAIN_W = 32;  // angle step gain
  localparam int DB_W   = 10;  // deadband limit
  localparam int CNT_W  = 4;   // calibration sample counter
  localparam int PROD_W = RATE_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  localparam int CAL_SAMPLES_DEF = 15;

  localparam int IN_DATA_W  = 48;   // three raw samples
  localparam int OUT_DATA_W = 192;  // three angles, three rates, zero fill
  localparam int OUT_USER_W = 2;

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP_GAIN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND_LIMIT  = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RST = 32'd200436;
  localparam logic [DB_W-1:0]   DB_RST   = 10'd2;

  // 360 degrees in 2^-32 degree units
  localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(64'd360 << 32);

  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic cal_add;  // add sample into bias sum
    logic upd;      // calibrated good sample: update rate
    logic s2_load;  // move front stage into multiply stage
    logic s3_load;  // move multiply stage into output stage
  } lane_ctl_t;

endpackage

@@ sv/gyro_drift_calibrated_angle_integrator_top.sv @@
// Top level of the three-axis gyro angle integrator: control pipeline, three
// axis lanes and output merge. Depends on gdai_pkg and gdai_lane.
//
// Takes one raw three-axis gyro sample per cycle while the output side does not
// stall and returns one result per sample, in order, through the front, multiply
// and output registers. The first CAL_SAMPLES samples after reset only build the
// per-axis bias sum (a failed read adds zero but still counts); results then
// show zero angles and rates. Afterwards each good sample is bias-corrected
// (raw*CAL_SAMPLES - bias), deadbanded, multiplied by angle_step_gain and added
// to the axis angle, which is wrapped once into 0..360 degrees and clamped.
// A failed read after calibration holds all state and flags read_fault.
// Rate: one item per cycle without output stalls. Each lane is a three-stage
// pipe (correction, gain multiply, accumulate); the angle accumulator closes its
// loop within the output stage, so consecutive samples never wait on each other.
// Stages collapse bubbles, so input fills empty stages while a result waits in
// the output register. Write configuration only while the block is idle.
module gyro_drift_calibrated_angle_integrator_top #(
  parameter int CAL_SAMPLES = gdai_pkg::CAL_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input samples
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [gdai_pkg::IN_DATA_W-1:0]       in_tdata,   // raw_rate_x, raw_rate_y, raw_rate_z
  input  logic                                 in_tuser,   // read_ok
  // results
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [gdai_pkg::OUT_DATA_W-1:0]      out_tdata,  // angle_x, angle_y, angle_z,
                                                           // rate_x, rate_y, rate_z, zero fill
  output logic [gdai_pkg::OUT_USER_W-1:0]      out_tuser,  // calibrated, read_fault
  // configuration
  input  logic                                 cfg_we,
  input  logic [gdai_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gdai_pkg::GAIN_W-1:0]          cfg_wdata
);

  localparam int NUM_AXES = 3;
  localparam int CW = gdai_pkg::CNT_W;

  logic [gdai_pkg::GAIN_W-1:0] gain_r;
  logic [gdai_pkg::DB_W-1:0]   deadband_r;

  logic [CW-1:0] cal_count_r, cal_count_nxt;
  logic          cal_done;
  logic          read_ok, accept;
  logic          v1_r, v2_r, out_valid_r;
  logic          en1, en2, en3;
  logic          calib_s1_r, calib_s2_r, calib_out_r;
  logic          fault_s1_r, fault_s2_r, fault_out_r;

  gdai_pkg::lane_ctl_t ctl;

  logic        [gdai_pkg::ANG_W-1:0]  angle [NUM_AXES];
  logic signed [gdai_pkg::RATE_W-1:0] rate  [NUM_AXES];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= gdai_pkg::GAIN_RST;
      deadband_r <= gdai_pkg::DB_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        gdai_pkg::REG_ANGLE_STEP_GAIN: gain_r     <= cfg_wdata;
        gdai_pkg::REG_DEADBAND_LIMIT:  deadband_r <= cfg_wdata[gdai_pkg::DB_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads
  assign en3       = !out_valid_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign accept    = in_tvalid && in_tready;
  assign read_ok   = in_tuser;

  // Calibration counter: advance on every transfer until done
  assign cal_done      = (cal_count_r >= CW'(CAL_SAMPLES));
  assign cal_count_nxt = (accept && !cal_done) ? cal_count_r + CW'(1) : cal_count_r;

  assign ctl.accept  = accept;
  assign ctl.cal_add = accept && !cal_done && read_ok;
  assign ctl.upd     = accept && cal_done && read_ok;
  assign ctl.s2_load = en2 && v1_r;
  assign ctl.s3_load = en3 && v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_count_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cal_count_r <= cal_count_nxt;
      if (en1) begin
        v1_r <= accept;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Status flags travel beside the lane data
  always_ff @(posedge clk) begin
    if (accept) begin
      calib_s1_r <= (cal_count_nxt >= CW'(CAL_SAMPLES));
      fault_s1_r <= !read_ok;
    end
    if (ctl.s2_load) begin
      calib_s2_r <= calib_s1_r;
      fault_s2_r <= fault_s1_r;
    end
    if (ctl.s3_load) begin
      calib_out_r <= calib_s2_r;
      fault_out_r <= fault_s2_r;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    gdai_lane #(
      .CAL_SAMPLES (CAL_SAMPLES)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .raw      ($signed(in_tdata[a*gdai_pkg::RAW_W +: gdai_pkg::RAW_W])),
      .gain     (gain_r),
      .deadband (deadband_r),
      .angle    (angle[a]),
      .rate     (rate[a])
    );
  end

  // Merge lane results into one transfer
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    {(gdai_pkg::OUT_DATA_W - 3*gdai_pkg::ANG_W - 3*gdai_pkg::RATE_W){1'b0}},
    rate[2], rate[1], rate[0], angle[2], angle[1], angle[0]
  };
  assign out_tuser  = {fault_out_r, calib_out_r};

endmodule

@@ sv/gdai_lane.sv @@
// One axis of the angle integrator: bias sum, deadband, gain multiply and
// wrapped angle accumulator. Depends on gdai_pkg.
module gdai_lane #(
  parameter int CAL_SAMPLES = gdai_pkg::CAL_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gdai_pkg::lane_ctl_t                 ctl,
  input  logic signed [gdai_pkg::RAW_W-1:0]   raw,
  input  logic        [gdai_pkg::GAIN_W-1:0]  gain,
  input  logic        [gdai_pkg::DB_W-1:0]    deadband,
  output logic        [gdai_pkg::ANG_W-1:0]   angle,
  output logic signed [gdai_pkg::RATE_W-1:0]  rate
);

  localparam int RW = gdai_pkg::RATE_W;
  localparam int BW = gdai_pkg::BIAS_W;
  localparam int AW = gdai_pkg::ANG_W;
  localparam int PW = gdai_pkg::PROD_W;
  localparam int SW = gdai_pkg::SUM_W;

  logic signed [BW-1:0] bias_r, bias_nxt;
  logic signed [RW-1:0] last_rate_r, last_rate_nxt;
  logic signed [RW-1:0] diff_s1_r, rate_s1_r, rate_s2_r, rate_out_r;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic        [AW-1:0] angle_acc_r, angle_acc_nxt;

  logic signed [RW-1:0] raw_w, bias_w, scaled, diff, mag, diff_db;
  logic signed [SW-1:0] ang_ext, prod_ext, full_ext, sum, wrapped;

  // Front stage: bias, correction, deadband
  assign raw_w    = {{(RW-gdai_pkg::RAW_W){raw[gdai_pkg::RAW_W-1]}}, raw};
  assign bias_w   = {{(RW-BW){bias_r[BW-1]}}, bias_r};
  assign scaled   = raw_w * $signed(RW'(CAL_SAMPLES));
  assign diff     = scaled - bias_w;
  assign mag      = diff[RW-1] ? -diff : diff;
  assign diff_db  = ($unsigned(mag) <= {{(RW-gdai_pkg::DB_W){1'b0}}, deadband}) ? '0 : diff;
  assign bias_nxt = ctl.cal_add
                  ? bias_r + {{(BW-gdai_pkg::RAW_W){raw[gdai_pkg::RAW_W-1]}}, raw}
                  : bias_r;
  assign last_rate_nxt = ctl.upd ? diff_db : last_rate_r;

  // Multiply stage
  assign prod_nxt = $signed({{(PW-RW){diff_s1_r[RW-1]}}, diff_s1_r})
                  * $signed({{(PW-gdai_pkg::GAIN_W){1'b0}}, gain});

  // Output stage: accumulate, wrap once, then clamp
  assign ang_ext  = $signed({{(SW-AW){1'b0}}, angle_acc_r});
  assign prod_ext = {{(SW-PW){prod_r[PW-1]}}, prod_r};
  assign full_ext = $signed({{(SW-AW){1'b0}}, gdai_pkg::FULL_TURN});
  assign sum      = ang_ext + prod_ext;

  always_comb begin
    wrapped = sum;
    if (sum > full_ext) begin
      wrapped = sum - full_ext;
      if (wrapped > full_ext) begin
        wrapped = full_ext;
      end
    end else if (sum < 0) begin
      wrapped = sum + full_ext;
      if (wrapped < 0) begin
        wrapped = '0;
      end
    end
    angle_acc_nxt = wrapped[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r      <= '0;
      last_rate_r <= '0;
      angle_acc_r <= '0;
    end else begin
      if (ctl.accept) begin
        bias_r      <= bias_nxt;
        last_rate_r <= last_rate_nxt;
      end
      if (ctl.s3_load) begin
        angle_acc_r <= angle_acc_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      diff_s1_r <= ctl.upd ? diff_db : '0;  // zero keeps the angle as is
      rate_s1_r <= last_rate_nxt;
    end
    if (ctl.s2_load) begin
      prod_r    <= prod_nxt;
      rate_s2_r <= rate_s1_r;
    end
    if (ctl.s3_load) begin
      rate_out_r <= rate_s2_r;
    end
  end

  assign angle = angle_acc_r;
  assign rate  = rate_out_r;

endmodule

@@ sv/gdai_checker.sv @@
// Port-level checker for the gyro angle integrator, bound to the top level.
// Depends on gdai_pkg.
module gdai_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [gdai_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic [gdai_pkg::OUT_USER_W-1:0]    out_tuser
);

  localparam int PAY_W = 3*gdai_pkg::ANG_W + 3*gdai_pkg::RATE_W;
  localparam int AW    = gdai_pkg::ANG_W;

  logic             seen_cal_r;
  logic [PAY_W-1:0] last_data_r;
  logic             out_xfer;

  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_cal_r  <= 1'b0;
      last_data_r <= '0;
    end else if (out_xfer) begin
      seen_cal_r  <= seen_cal_r || out_tuser[0];
      last_data_r <= out_tdata[PAY_W-1:0];
    end
  end

  // Once calibrated, stay calibrated until reset
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_cal_r |-> out_tuser[0])
    else $error("calibrated flag dropped");

  // Calibration results carry zero angles and rates
  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[PAY_W-1:0] == '0)
    else $error("nonzero data during calibration");

  // A failed read repeats the previous result
  a_fault_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[PAY_W-1:0] == last_data_r)
    else $error("state changed on failed read");

  // Angles stay within one turn
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[AW-1:0] <= gdai_pkg::FULL_TURN
                && out_tdata[2*AW-1:AW] <= gdai_pkg::FULL_TURN
                && out_tdata[3*AW-1:2*AW] <= gdai_pkg::FULL_TURN)
    else $error("angle out of range");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

endmodule

bind gyro_drift_calibrated_angle_integrator_top gdai_checker u_gdai_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ bench/gdai_tb_pkg.sv @@
// Scoreboard for the gyro angle integrator bench: result layout, predictor of
// calibration, deadband, gain and angle wrap, and the in-order result check.
// Depends on gdai_pkg.
package gdai_tb_pkg;
  import gdai_pkg::*;

  typedef struct packed {
    logic [2:0][ANG_W-1:0]  angle;
    logic [2:0][RATE_W-1:0] rate;
    logic                   calibrated;
    logic                   read_fault;
  } gyro_result_t;

  class gyro_angle_checker;
    int                cal_samples;
    logic [GAIN_W-1:0] gain;
    logic [DB_W-1:0]   deadband;
    int                cal_count;
    longint            bias[3];
    longint            angle[3];
    longint            rate[3];
    gyro_result_t      pending_results[$];
    int unsigned       mismatches;

    function new(int cal_samples_n);
      cal_samples = cal_samples_n;
      gain        = GAIN_RST;
      deadband    = DB_RST;
      cal_count   = 0;
      mismatches  = 0;
      for (int a = 0; a < 3; a++) begin
        bias[a]  = 0;
        angle[a] = 0;
        rate[a]  = 0;
      end
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [GAIN_W-1:0] data);
      if (addr == REG_ANGLE_STEP_GAIN) gain = data;
      else if (addr == REG_DEADBAND_LIMIT) deadband = data[DB_W-1:0];
    endfunction

    function longint bias_of(int axis);
      return bias[axis];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advance the predicted state by one sample and queue the result it causes.
    function void note_sample(logic [IN_DATA_W-1:0] data, logic ok);
      gyro_result_t r;
      longint       raw, diff, mag, ang, full;
      bit           in_cal;
      full   = longint'(FULL_TURN);
      in_cal = cal_count < cal_samples;
      for (int a = 0; a < 3; a++) begin
        raw = longint'($signed(data[a*RAW_W +: RAW_W]));
        if (in_cal) begin
          if (ok) bias[a] += raw;
        end else if (ok) begin
          diff = raw * longint'(cal_samples) - bias[a];
          mag  = (diff < 0) ? -diff : diff;
          if (mag <= longint'(deadband)) diff = 0;
          rate[a] = diff;
          ang = angle[a] + diff * longint'(gain);
          if (ang > full) ang -= full;
          else if (ang < 0) ang += full;
          // saturate what one wrap cannot bring back into range
          if (ang > full) ang = full;
          else if (ang < 0) ang = 0;
          angle[a] = ang;
        end
      end
      if (in_cal) cal_count++;
      for (int a = 0; a < 3; a++) begin
        r.angle[a] = ANG_W'(angle[a]);
        r.rate[a]  = RATE_W'(rate[a]);
      end
      r.calibrated = (cal_count >= cal_samples);
      r.read_fault = !ok;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      gyro_result_t      exp;
      logic [ANG_W-1:0]  got_angle;
      logic [RATE_W-1:0] got_rate;
      string             axis;
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      for (int a = 0; a < 3; a++) begin
        axis      = (a == 0) ? "x" : (a == 1) ? "y" : "z";
        got_angle = data[a*ANG_W +: ANG_W];
        got_rate  = data[3*ANG_W + a*RATE_W +: RATE_W];
        if (got_angle !== exp.angle[a]) begin
          $error("angle_%s: expected %0d, actual %0d", axis, exp.angle[a], got_angle);
          mismatches++;
        end
        if (got_rate !== exp.rate[a]) begin
          $error("rate_%s: expected %0d, actual %0d", axis,
                 $signed(exp.rate[a]), $signed(got_rate));
          mismatches++;
        end
      end
      if (user[0] !== exp.calibrated) begin
        $error("calibrated: expected %0d, actual %0d", exp.calibrated, user[0]);
        mismatches++;
      end
      if (user[1] !== exp.read_fault) begin
        $error("read_fault: expected %0d, actual %0d", exp.read_fault, user[1]);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ bench/gyro_drift_calibrated_angle_integrator_top_test.sv @@
// Self-checking bench for the gyro angle integrator top level: calibration,
// deadband edge, saturation and random phases under random stalls on both
// sides. Depends on gdai_pkg, gdai_tb_pkg and the RTL top level.
module gyro_drift_calibrated_angle_integrator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gdai_pkg::*;
  import gdai_tb_pkg::*;

  localparam int CAL_N           = CAL_SAMPLES_DEF;
  localparam int STALL_LIMIT     = 4000;  // cycles without any transfer
  localparam int HOLD_OFF_CYCLES = 80;    // long receiver stall, fills the pipe
  localparam int DRAIN_CYCLES    = 12;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 48;

  // indexes past the two registers: writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // raw_rate_x, raw_rate_y, raw_rate_z
  logic                  in_tuser;   // read_ok
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // angle_x, angle_y, angle_z, rate_x, rate_y, rate_z, fill
  logic [OUT_USER_W-1:0] out_tuser;  // calibrated, read_fault
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [GAIN_W-1:0]     cfg_wdata;

  gyro_angle_checker sb;
  bit                gaps_on;      // both sides draw random idle cycles when set
  int                stall_cycles = 0;

  gyro_drift_calibrated_angle_integrator_top #(
    .CAL_SAMPLES(CAL_N)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if nothing transfers on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Pick one raw sample: mostly full random, some extremes, some close to the
  // axis bias so that the corrected rate lands around the deadband.
  function automatic logic [RAW_W-1:0] pick_raw(int axis);
    longint center;
    case ($urandom_range(0, 9))
      0: pick_raw = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2: begin
        center   = sb.bias_of(axis) / CAL_N;
        pick_raw = RAW_W'(center + longint'($urandom_range(0, 160)) - 80);
      end
      default: pick_raw = RAW_W'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until the input transfer. Called and
  // returns at a falling edge; tvalid is left high for back-to-back offers.
  task automatic send_sample(input logic [RAW_W-1:0] x, y, z, input logic ok);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    in_tuser  <= ok;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(in_tdata, in_tuser);
    @(negedge clk);
  endtask

  task automatic send_random_sample();
    logic ok;
    ok = ($urandom_range(0, 99) < 85);
    send_sample(pick_raw(0), pick_raw(1), pick_raw(2), ok);
  endtask

  // Drop tvalid and wait until every expected result has been taken.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [GAIN_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sb.write_reg(addr, data);
  endtask

  // Result side: random tready gaps, one long hold-off at two points, and a
  // check of every output transfer against the oldest expectation.
  initial begin : result_sink
    int wait_n;
    int results_seen;
    out_tready   = 1'b0;
    results_seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      wait_n = gaps_on ? $urandom_range(0, 7) : 0;
      if (results_seen == 150 || results_seen == 320) wait_n = HOLD_OFF_CYCLES;
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser);
      results_seen++;
    end
  end

  initial begin : stimulus
    longint           center, d;
    logic [GAIN_W-1:0] gain_word, db_word;
    sb        = new(CAL_N);
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_ANGLE_STEP_GAIN;
    cfg_wdata = '0;
    gaps_on   = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Calibration with reset register values: extremes, failed reads that
    // still count as calibration samples, and random filler.
    send_sample(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
    send_sample(16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(16'h0001, 16'h0000, 16'h7FFF, 1'b1);
    for (int i = 4; i < CAL_N; i++) begin
      send_sample(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom), i != 9);
    end

    // First calibrated sample, then a failed read that must hold state.
    send_sample(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
    send_sample(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom), 1'b0);

    // Deadband edge on X: set the limit to exactly the next corrected rate,
    // so that sample reads as zero and the one after it passes.
    settle();
    center = sb.bias_of(0) / CAL_N + 5;
    d      = center * CAL_N - sb.bias_of(0);
    write_reg(REG_DEADBAND_LIMIT, GAIN_W'((d < 0) ? -d : d));
    send_sample(RAW_W'(center), pick_raw(1), pick_raw(2), 1'b1);
    send_sample(RAW_W'(center + 1), pick_raw(1), pick_raw(2), 1'b1);

    // Full-scale gain: increments far beyond one turn saturate at both ends.
    // The deadband write carries junk above bit 9 that must be dropped.
    settle();
    write_reg(REG_ANGLE_STEP_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_DEADBAND_LIMIT, 32'hFFFF_FC00);
    send_sample(16'h7FFF, 16'h8000, pick_raw(2), 1'b1);
    send_sample(16'h8000, 16'h7FFF, pick_raw(2), 1'b1);

    // Zero gain, and writes to unused indexes that must be ignored.
    settle();
    write_reg(REG_ANGLE_STEP_GAIN, 32'd0);
    write_reg(REG_SPARE_2, GAIN_W'($urandom));
    write_reg(REG_SPARE_3, GAIN_W'($urandom));
    send_sample(pick_raw(0), pick_raw(1), pick_raw(2), 1'b1);

    // Random phases, each under its own register setting; every third phase
    // runs without idle cycles on either side.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      gaps_on = (p % 3) != 2;
      case (p % 5)
        0: gain_word = GAIN_RST;
        1: gain_word = GAIN_W'($urandom);
        2: gain_word = GAIN_W'($urandom_range(0, 4095));
        3: gain_word = 32'hFFFF_FFFF;
        default: gain_word = 32'd0;
      endcase
      if (p == 3) db_word = 32'hFFFF_FFFF;
      else if (p == 6) db_word = 32'd0;
      else db_word = GAIN_W'($urandom);
      write_reg(REG_ANGLE_STEP_GAIN, gain_word);
      write_reg(REG_DEADBAND_LIMIT, db_word);
      if (p % 2) write_reg((p % 4 == 1) ? REG_SPARE_2 : REG_SPARE_3, GAIN_W'($urandom));
      repeat (PHASE_ITEMS) send_random_sample();
    end

    // Drain: wait for every expected result, then a few quiet cycles to catch
    // any stray output transfer.
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/gdai_pkg.sv
sv/gdai_lane.sv
sv/gyro_drift_calibrated_angle_integrator_top.sv
sv/gdai_checker.sv
bench/gdai_tb_pkg.sv
bench/gyro_drift_calibrated_angle_integrator_top_test.sv
